// ----- hdl/buc_pkg.sv -----
// Shared constants and command/status types for the busiest-core utilisation block.
// No dependencies; imported by buc_ctrl, buc_datapath and busiest_core_utilization.
`default_nettype none

package buc_pkg;

   // store depth and addressing
   localparam int MAX_CORES = 64;
   localparam int CORE_AW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam logic [6:0] CORE_LIMIT = 7'(MAX_CORES);

   // field widths
   localparam int CORE_W = 6;
   localparam int TICK_W = 64;
   localparam int PCT_W  = 15;

   // 25600 = 2^14 + 2^13 + 2^10, scaled dividend width
   localparam int PROD_W = TICK_W + PCT_W;
   localparam logic [PCT_W-1:0] FULL_SCALE = 15'd25600;

   // one quotient bit per divider step
   localparam int DIV_STEPS = PCT_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS);
   localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);

   typedef struct packed {
      logic load_item;   // capture an accepted transfer
      logic read_mem;    // read previous idle/total of the core
      logic calc_delta;  // register idle and total deltas
      logic calc_num;    // busy delta = total delta - idle delta
      logic write_mem;   // store this sample as the new previous one
      logic set_full;    // idle delta above total delta: 100 percent
      logic mul_a;       // first half of the scale by 25600
      logic mul_b;       // second half, loads the divider
      logic div_step;    // one restoring division step
      logic fold;        // fold the reading into the poll maximum
      logic end_poll;    // load the result and clear the poll state
   } buc_cmd_type;

   typedef struct packed {
      logic core_ok;     // core index below MAX_CORES
      logic last;        // item closes the poll
      logic baseline;    // a full poll has been seen
      logic nonzero;     // total delta nonzero
      logic over;        // idle delta above total delta
   } buc_status_type;

endpackage

`default_nettype wire

// ----- hdl/buc_datapath.sv -----
// Datapath: item registers, previous-sample stores, deltas, scaling, divider, poll maximum.
// Depends on buc_pkg; driven by buc_ctrl through buc_cmd_type.
`default_nettype none

module buc_datapath
   import buc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire buc_cmd_type         cmd,
   output buc_status_type           status,
   input  wire logic [CORE_W-1:0]   core_index,
   input  wire logic [TICK_W-1:0]   idle_ticks,
   input  wire logic [TICK_W-1:0]   kernel_ticks,
   input  wire logic [TICK_W-1:0]   user_ticks,
   input  wire logic                last_core,
   output logic [PCT_W-1:0]         busiest_pct,
   output logic                     have_reading
);

   logic [TICK_W-1:0] prev_idle  [MAX_CORES];
   logic [TICK_W-1:0] prev_total [MAX_CORES];

   logic [CORE_W-1:0] core_ff;
   logic [TICK_W-1:0] idle_ff, total_ff;
   logic              last_ff;
   logic [TICK_W-1:0] rd_idle_ff, rd_total_ff;
   logic [TICK_W-1:0] d_idle_ff, d_total_ff, num_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [TICK_W-1:0] rem_ff;
   logic [PCT_W-1:0]  nlo_ff, q_ff;
   logic [PCT_W-1:0]  max_ff, max_in;
   logic              any_ff, any_in, base_ff, base_in;
   logic [PCT_W-1:0]  pct_ff;
   logic              have_ff;

   logic [CORE_AW-1:0] addr;
   logic [PROD_W-1:0]  num_ext, prod;
   logic [TICK_W:0]    trial, diff;
   logic               take;

   assign addr    = core_ff[CORE_AW-1:0];
   assign num_ext = {{PCT_W{1'b0}}, num_ff};
   assign prod    = acc_ff + (num_ext << 10);

   // restoring step; remainder stays below the divisor
   assign trial = {rem_ff, nlo_ff[PCT_W-1]};
   assign diff  = trial - {1'b0, d_total_ff};
   assign take  = !diff[TICK_W];

   assign status.core_ok  = {1'b0, core_ff} < CORE_LIMIT;
   assign status.last     = last_ff;
   assign status.baseline = base_ff;
   assign status.nonzero  = d_total_ff != '0;
   assign status.over     = d_idle_ff > d_total_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         core_ff  <= core_index;
         idle_ff  <= idle_ticks;
         total_ff <= kernel_ticks + user_ticks;
         last_ff  <= last_core;
      end
      if (cmd.read_mem) begin
         rd_idle_ff  <= prev_idle[addr];
         rd_total_ff <= prev_total[addr];
      end
      if (cmd.write_mem) begin
         prev_idle[addr]  <= idle_ff;
         prev_total[addr] <= total_ff;
      end
      if (cmd.calc_delta) begin
         d_idle_ff  <= idle_ff - rd_idle_ff;
         d_total_ff <= total_ff - rd_total_ff;
      end
      if (cmd.calc_num) begin
         num_ff <= d_total_ff - d_idle_ff;
      end
      if (cmd.mul_a) begin
         acc_ff <= (num_ext << 14) + (num_ext << 13);
      end
      if (cmd.mul_b) begin
         rem_ff <= prod[PROD_W-1:PCT_W];
         nlo_ff <= prod[PCT_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= take ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
         nlo_ff <= {nlo_ff[PCT_W-2:0], 1'b0};
      end
      if (cmd.set_full) begin
         q_ff <= FULL_SCALE;
      end else if (cmd.div_step) begin
         q_ff <= {q_ff[PCT_W-2:0], take};
      end
      if (cmd.end_poll) begin
         pct_ff  <= any_ff ? max_ff : '0;
         have_ff <= any_ff;
      end
   end

   always_comb begin
      max_in  = max_ff;
      any_in  = any_ff;
      base_in = base_ff;
      if (cmd.fold) begin
         any_in = 1'b1;
         if (q_ff > max_ff) max_in = q_ff;
      end
      if (cmd.end_poll) begin
         max_in  = '0;
         any_in  = 1'b0;
         base_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         any_ff  <= 1'b0;
         base_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         any_ff  <= any_in;
         base_ff <= base_in;
      end
   end

   assign busiest_pct  = pct_ff;
   assign have_reading = have_ff;

endmodule

`default_nettype wire

// ----- hdl/buc_ctrl.sv -----
// Controller: sequences one sample through read, delta, scale, divide and fold.
// Depends on buc_pkg; drives buc_datapath, owns both handshakes.
`default_nettype none

module buc_ctrl
   import buc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire buc_status_type status,
   output buc_cmd_type         cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_READ   = 4'd1;
   localparam logic [3:0] ST_DELTA  = 4'd2;
   localparam logic [3:0] ST_EVAL   = 4'd3;
   localparam logic [3:0] ST_MUL1   = 4'd4;
   localparam logic [3:0] ST_MUL2   = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_FOLD   = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic              reading;

   assign reading    = status.core_ok && status.baseline && status.nonzero;
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_mem = 1'b1;
            state_in     = ST_DELTA;
         end
         ST_DELTA: begin
            cmd.calc_delta = 1'b1;
            state_in       = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.write_mem = status.core_ok;
            cmd.calc_num  = 1'b1;
            if (!reading) begin
               state_in = ST_FINISH;
            end else if (status.over) begin
               cmd.set_full = 1'b1;
               state_in     = ST_FOLD;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_b = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (!valid_ff || rsp_tready) begin
               cmd.end_poll = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/busiest_core_utilization.sv -----
// Top level of the busiest-core utilisation monitor: stream ports, controller and datapath.
// Depends on buc_pkg, buc_ctrl and buc_datapath.
`default_nettype none

// Each request transfer carries one core's cumulative idle, kernel and user tick counts;
// tlast marks the final core of a poll. Previous idle and total (kernel + user, modulo
// 2^64) are kept per core in two 64-entry stores. From the second poll on, each core with
// a nonzero total delta reports busy = (total delta - idle delta) * 25600 / total delta,
// unsigned Q7.8 percent, truncated, or 100 percent when idle delta exceeds total delta.
// The last transfer of a poll produces one response: the poll maximum and a reading flag
// (both zero when no core reported, which includes the first poll). Core indices at or
// above MAX_CORES are ignored, though their tlast still closes the poll. A sample with a
// division runs through the ready cycle, store read, delta, evaluate, two scaling adds, 15
// steps of a one-bit restoring divider, fold and finish; a clamp to full scale skips the
// scaling adds and the divider, and a core with no reading also skips the fold. The last
// sample of a poll also waits in finish while the previous response is still unaccepted.
// The request side is ready only between samples; a finished response waits in its output
// register while the next sample is already taken in. The stores have no reset: a core must
// appear in a poll before its deltas mean anything.

module busiest_core_utilization
   import buc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request: core_index[5:0], idle_ticks[69:6], kernel_ticks[133:70],
   //          user_ticks[197:134], zero pad [199:198]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [199:0] req_tdata,
   input  wire logic         req_tlast,   // last_core
   // response: busiest_pct[14:0], zero pad [15]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tuser    // have_reading
);

   buc_cmd_type    cmd;
   buc_status_type status;
   logic [PCT_W-1:0] busiest_pct;
   logic             have_reading;

   buc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   buc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .core_index   (req_tdata[5:0]),
      .idle_ticks   (req_tdata[69:6]),
      .kernel_ticks (req_tdata[133:70]),
      .user_ticks   (req_tdata[197:134]),
      .last_core    (req_tlast),
      .busiest_pct  (busiest_pct),
      .have_reading (have_reading)
   );

   assign rsp_tdata = {1'b0, busiest_pct};
   assign rsp_tuser = have_reading;

endmodule

`default_nettype wire

// ----- verif/busiest_core_utilization_test.sv -----
// Self-checking testbench for busiest_core_utilization: directed polls, then random polls.
// Uses buc_pkg for widths and the full-scale constant; needs nothing but the RTL.
`default_nettype none

module busiest_core_utilization_test;
   import buc_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int STALL_PCT    = 9;     // idle/stall chance per cycle, percent
   localparam int DRAIN_CYCLES = 60;    // well past one sample's run through the controller
   localparam int HANG_LIMIT   = 4000;  // cycles with no transfer before giving up

   typedef struct packed {
      logic [CORE_W-1:0] core;
      logic [TICK_W-1:0] idle;
      logic [TICK_W-1:0] kernel;
      logic [TICK_W-1:0] user;
      logic              last;
   } core_sample_type;

   typedef struct packed {
      logic [PCT_W-1:0] pct;
      logic             have;
   } poll_result_type;

   // fixed = 1: the poll result is typed in and used instead of the prediction
   typedef struct packed {
      core_sample_type s;
      logic            fixed;
      poll_result_type r;
   } table_row_type;

   localparam logic [TICK_W-1:0] ONES = {TICK_W{1'b1}};

   // Directed polls. The first poll is the baseline and writes every core used later.
   table_row_type directed_rows [16] = '{
      // baseline poll: extremes of every counter, no reading allowed
      '{'{6'd0,  64'd0,    64'd0,    64'd0,    1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd63, ONES,     ONES,     ONES,     1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd21, 64'd1000, 64'd3000, 64'd1000, 1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd42, 64'd500,  64'd800,  64'd200,  1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd7,  64'd0,    64'd100,  64'd0,    1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd56, 64'd10,   64'd20,   64'd30,   1'b1}, 1'b1, '{15'd0, 1'b0}},
      // unchanged counters: zero total delta, no reading
      '{'{6'd0,  64'd0,    64'd0,    64'd0,    1'b1}, 1'b1, '{15'd0, 1'b0}},
      // idle delta 100 against total delta 50: clamps to full scale
      '{'{6'd21, 64'd1100, 64'd3000, 64'd1050, 1'b1}, 1'b1, '{15'd25600, 1'b1}},
      // idle delta equals total delta: a valid reading of zero
      '{'{6'd42, 64'd600,  64'd850,  64'd250,  1'b1}, 1'b1, '{15'd0, 1'b1}},
      // total wraps through zero, no idle: 100 percent; then 3/4 busy
      '{'{6'd63, ONES,     64'd0,    64'd5,    1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd0,  64'd1,    64'd4,    64'd0,    1'b1}, 1'b1, '{15'd25600, 1'b1}},
      // same core twice in one poll, truncated two-thirds
      '{'{6'd7,  64'd1,    64'd103,  64'd0,    1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd7,  64'd4,    64'd106,  64'd0,    1'b0}, 1'b0, '{15'd0, 1'b0}},
      '{'{6'd56, 64'd11,   64'd20,   64'd33,   1'b1}, 1'b0, '{15'd0, 1'b0}},
      // near-full-width deltas through the divider
      '{'{6'd63, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0, 1'b0},
        1'b0, '{15'd0, 1'b0}},
      '{'{6'd21, 64'd1100, 64'd4050, 64'd1,    1'b1}, 1'b0, '{15'd0, 1'b0}}
   };

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata  = '0;   // core_index, idle, kernel, user, zero pad
   logic         req_tlast  = 1'b0; // last_core
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;         // busiest_pct, zero pad
   logic         rsp_tuser;         // have_reading

   // shadow of the block's per-core stores and poll state
   logic [TICK_W-1:0] prev_idle  [MAX_CORES];
   logic [TICK_W-1:0] prev_total [MAX_CORES];
   bit                core_known [MAX_CORES];
   int                known_cores[$];
   bit                seen_baseline;
   logic [PCT_W-1:0]  poll_peak;
   bit                poll_any;

   poll_result_type awaited_readings[$];
   poll_result_type head_reading;
   int              mismatches;
   int              quiet_cycles;
   bit              steady;         // set: neither side idles

   busiest_core_utilization dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Folds one accepted sample into the shadow state; closes is set on the
   // final sample of a poll, with the poll result in r.
   task automatic predict_sample(input core_sample_type s, output bit closes,
                                 output poll_result_type r);
      logic [TICK_W-1:0]   total;
      logic [TICK_W-1:0]   d_idle;
      logic [TICK_W-1:0]   d_total;
      logic [2*TICK_W-1:0] quotient;
      logic [PCT_W-1:0]    pct;
      total = s.kernel + s.user;
      if (int'(s.core) < MAX_CORES) begin
         if (seen_baseline) begin
            d_idle  = s.idle - prev_idle[s.core];
            d_total = total - prev_total[s.core];
            if (d_total != '0) begin
               if (d_idle > d_total) begin
                  pct = FULL_SCALE;
               end else begin
                  quotient = ({{TICK_W{1'b0}}, d_total - d_idle} * (2*TICK_W)'(FULL_SCALE))
                             / {{TICK_W{1'b0}}, d_total};
                  pct = quotient[PCT_W-1:0];
               end
               if (pct > FULL_SCALE) pct = FULL_SCALE;
               if (pct > poll_peak) poll_peak = pct;
               poll_any = 1'b1;
            end
         end
         prev_idle[s.core]  = s.idle;
         prev_total[s.core] = total;
         if (!core_known[s.core]) begin
            core_known[s.core] = 1'b1;
            known_cores.push_back(int'(s.core));
         end
      end
      closes = s.last;
      r.pct  = poll_any ? poll_peak : '0;
      r.have = poll_any;
      if (s.last) begin
         poll_peak     = '0;
         poll_any      = 1'b0;
         seen_baseline = 1'b1;
      end
   endtask

   function automatic logic [TICK_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // nonzero value of random bit length, 1 to 64 bits
   function automatic logic [TICK_W-1:0] rand_span();
      logic [TICK_W-1:0] w;
      w = rand_word() >> $urandom_range(0, TICK_W - 1);
      return (w == '0) ? 64'd1 : w;
   endfunction

   // Random sample for a core whose stores are already written, shaped by the
   // wanted deltas so that every branch of the busy calculation is reached.
   function automatic core_sample_type make_sample(input logic last);
      core_sample_type   s;
      logic [TICK_W-1:0] d_idle;
      logic [TICK_W-1:0] d_total;
      int                c;
      bit                scramble;
      c = $urandom_range(0, MAX_CORES - 1);
      if (!core_known[c]) c = known_cores[$urandom_range(0, known_cores.size() - 1)];
      scramble = 1'b0;
      d_total  = rand_span();
      case ($urandom_range(0, 9))
         0: begin                       // no interval: no reading
            d_idle  = $urandom_range(0, 1) ? '0 : rand_span();
            d_total = '0;
         end
         1: begin                       // idle ran ahead of total: clamp
            d_total = d_total >> 1;
            if (d_total == '0) d_total = 64'd1;
            d_idle  = d_total + 64'd1 + 64'($urandom_range(0, 1000));
         end
         2: d_idle = '0;                // fully busy
         3: d_idle = d_total;           // fully idle
         4: scramble = 1'b1;            // unrelated counters
         5: d_idle = d_total >> $urandom_range(1, 8);
         default: d_idle = rand_word() & d_total;
      endcase
      s.core   = c[CORE_W-1:0];
      s.idle   = prev_idle[c] + d_idle;
      s.kernel = rand_word();
      s.user   = prev_total[c] + d_total - s.kernel;
      s.last   = last;
      if (scramble) begin
         s.idle = rand_word();
         s.user = rand_word();
      end
      return s;
   endfunction

   // Presents one sample, waits for its transfer, then records what it predicts.
   task automatic send_sample(input core_sample_type s, input bit fixed,
                              input poll_result_type fixed_r);
      bit              closes;
      poll_result_type r;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, s.user, s.kernel, s.idle, s.core};
      req_tlast  <= s.last;
      do @(posedge clock); while (!req_tready);
      predict_sample(s, closes, r);
      if (closes) awaited_readings.push_back(fixed ? fixed_r : r);
   endtask

   // response side: random back-pressure, none during the steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
   end

   // response checker: every transfer against the oldest awaited reading
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_readings.size() == 0) begin
            report_mismatch("response with nothing awaited, pct", 32'(rsp_tdata), 0);
         end else begin
            head_reading = awaited_readings.pop_front();
            if (rsp_tdata[PCT_W-1:0] !== head_reading.pct)
               report_mismatch("busiest_pct", 32'(rsp_tdata[PCT_W-1:0]),
                               32'(head_reading.pct));
            if (rsp_tuser !== head_reading.have)
               report_mismatch("have_reading", 32'(rsp_tuser), 32'(head_reading.have));
         end
      end
   end

   // watchdog: a run of cycles with no transfer on either side is a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("busiest_core_utilization_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int sent;
      int poll_len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].s, directed_rows[i].fixed, directed_rows[i].r);

      // random polls, mostly short, now and then a long one
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         poll_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                : $urandom_range(1, 6);
         for (int k = 0; k < poll_len; k++) begin
            steady = (sent >= 500 && sent < 800);
            send_sample(make_sample(k == poll_len - 1), 1'b0, '0);
            sent++;
         end
      end
      steady = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then give any stray response time to show up
      while (awaited_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("busiest_core_utilization_test: clean");
      end else begin
         $display("busiest_core_utilization_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- busiest_core_utilization.f -----
hdl/buc_pkg.sv
hdl/buc_datapath.sv
hdl/buc_ctrl.sv
hdl/busiest_core_utilization.sv
verif/busiest_core_utilization_test.sv
